// File: src/facr_pkg.sv
// facr_pkg: sizes, line and control types and helper functions for the
// fully associative tag store with random replacement
// no dependencies
`default_nettype none

package facr_pkg;

    // storage geometry (power-of-two sizes)
    localparam int CACHE_BYTES = 65536;
    localparam int ADDR_BITS   = 26;
    localparam int MAX_LINES   = 4096;

    // line size register
    localparam int LSL_W     = 3;
    localparam int MIN_SHIFT = 4;

    // tag is the address with at least MIN_SHIFT offset bits dropped
    localparam int TAG_W = ADDR_BITS - MIN_SHIFT;

    // line index and fill counter widths
    localparam int LINE_IDX_W = $clog2(MAX_LINES);
    localparam int FILL_W     = LINE_IDX_W + 1;

    // chain of cells, each cell owns one bank of lines
    localparam int NUM_CELLS  = (MAX_LINES >= 4096) ? 64 : 8;
    localparam int BANK_DEPTH = MAX_LINES / NUM_CELLS;
    localparam int CELL_W     = $clog2(NUM_CELLS);
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam int DRAIN_W    = $clog2(NUM_CELLS + 1);

    // multiply-with-carry generator
    localparam logic [15:0] RNG_Z_MUL  = 16'd36969;
    localparam logic [15:0] RNG_W_MUL  = 16'd18000;
    localparam logic [31:0] RNG_Z_INIT = 32'h0508_0902;
    localparam logic [31:0] RNG_W_INIT = 32'hABAB_AB55;

    localparam logic [LSL_W-1:0] LSL_RESET = LSL_W'(MIN_SHIFT);

    // one stored line
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             cmp_en;
        logic [TAG_W-1:0] tag;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        line_t            wr_line;
    } cell_ctl_t;

    // offset bits in use: values below the minimum act as the minimum
    function automatic logic [LSL_W-1:0] eff_shift(input logic [LSL_W-1:0] lsl);
        logic [LSL_W-1:0] s;
        s = (lsl < LSL_W'(MIN_SHIFT)) ? LSL_W'(MIN_SHIFT) : lsl;
        return s;
    endfunction

    // number of lines for a line size, capped at the storage size
    function automatic logic [FILL_W-1:0] line_count(input logic [LSL_W-1:0] lsl);
        logic [31:0] n;
        n = 32'(CACHE_BYTES) >> eff_shift(lsl);
        if (n > 32'(MAX_LINES)) begin
            n = 32'(MAX_LINES);
        end
        if (n == 32'd0) begin
            n = 32'd1;
        end
        return n[FILL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/facr_ram.sv
// facr_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
`default_nettype none

module facr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/facr_cell.sv
// facr_cell: one tag bank with its compare, passing the hit flag down the chain
// depends on facr_pkg and facr_ram
`default_nettype none

module facr_cell
    import facr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_ctl_t ctl,
    input  wire logic      wr_sel,
    input  wire logic      hit_in,
    output logic           hit_out
);

    logic [LINE_W-1:0] rd_bits;
    line_t             rd_line;
    logic              match;
    logic              hit_reg;
    logic              hit_next;

    // tag bank for the lines owned by this cell
    facr_ram #(
        .WIDTH (LINE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .aclk  (aclk),
        .we    (ctl.wr_en & wr_sel),
        .waddr (ctl.wr_row),
        .wdata (ctl.wr_line),
        .re    (ctl.rd_en),
        .raddr (ctl.rd_row),
        .rdata (rd_bits)
    );

    // compare the row read last cycle against the broadcast tag
    assign rd_line  = line_t'(rd_bits);
    assign match    = ctl.cmp_en & rd_line.valid & (rd_line.tag == ctl.tag);
    assign hit_next = hit_in | match;

    // hit flag stage toward the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign hit_out = hit_reg;

endmodule

`default_nettype wire

// File: src/facr_ctrl.sv
// facr_ctrl: sequencer for row sweep, hit collection, fill counter,
// random victim choice, clearing pass and the output register
// depends on facr_pkg
`default_nettype none

module facr_ctrl
    import facr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ADDR_BITS-1:0] s_addr,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit,
    input  wire logic                 cfg_we,
    input  wire logic [LSL_W-1:0]     cfg_wdata,
    input  wire logic                 chain_hit,
    output cell_ctl_t                 ctl,
    output logic      [NUM_CELLS-1:0] wr_sel
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b000_0001,
        ST_IDLE   = 7'b000_0010,
        ST_SWEEP  = 7'b000_0100,
        ST_DRAIN  = 7'b000_1000,
        ST_DECIDE = 7'b001_0000,
        ST_WRITE  = 7'b010_0000,
        ST_DONE   = 7'b100_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [DRAIN_W-1:0]    drain_reg, drain_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic                  hit_acc_reg, hit_acc_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [31:0]           z_reg, z_next;
    logic [31:0]           w_reg, w_next;
    logic                  use_rand_reg, use_rand_next;
    logic [LINE_IDX_W-1:0] victim_reg, victim_next;
    logic [LSL_W-1:0]      lsl_reg, lsl_next;
    logic                  cmp_en_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg, out_hit_next;

    logic                  accept;
    logic                  out_load;
    logic [FILL_W-1:0]     lines;
    logic [LINE_IDX_W-1:0] line_mask;
    logic [ADDR_BITS-1:0]  addr_shifted;
    logic [31:0]           z_prod, w_prod;
    logic [31:0]           z_step, w_step;
    logic [31:0]           rand_sum;
    logic [LINE_IDX_W-1:0] victim;
    logic [CELL_W-1:0]     victim_cell;
    logic [ROW_W-1:0]      victim_row;

    // line geometry from the line size register
    assign lines     = line_count(lsl_reg);
    assign line_mask = LINE_IDX_W'(lines - FILL_W'(1));

    // tag of the incoming address
    assign addr_shifted = s_addr >> eff_shift(lsl_reg);

    // multiply-with-carry step
    assign z_prod = 32'(z_reg[15:0]) * 32'(RNG_Z_MUL);
    assign w_prod = 32'(w_reg[15:0]) * 32'(RNG_W_MUL);
    assign z_step = z_prod + {16'd0, z_reg[31:16]};
    assign w_step = w_prod + {16'd0, w_reg[31:16]};

    // victim line: fill slot or random value masked to the line count
    assign rand_sum    = {z_reg[15:0], 16'd0} + w_reg;
    assign victim      = use_rand_reg ? (rand_sum[LINE_IDX_W-1:0] & line_mask) : victim_reg;
    assign victim_cell = victim[CELL_W-1:0];
    assign victim_row  = victim[LINE_IDX_W-1:CELL_W];

    // handshakes
    assign s_ready  = (state_reg == ST_IDLE) & ~cfg_we;
    assign accept   = s_valid & s_ready;
    assign out_load = (state_reg == ST_DONE) & (~out_valid_reg | m_ready);
    assign m_valid  = out_valid_reg;
    assign m_hit    = out_hit_reg;

    // broadcast to the cells
    always_comb begin
        ctl.rd_en         = (state_reg == ST_SWEEP);
        ctl.rd_row        = row_reg;
        ctl.cmp_en        = cmp_en_reg;
        ctl.tag           = tag_reg;
        ctl.wr_en         = (state_reg == ST_CLEAR) | (state_reg == ST_WRITE);
        ctl.wr_row        = (state_reg == ST_CLEAR) ? row_reg : victim_row;
        ctl.wr_line.valid = (state_reg == ST_WRITE);
        ctl.wr_line.tag   = tag_reg;
        for (int k = 0; k < NUM_CELLS; k++) begin
            wr_sel[k] = (state_reg == ST_CLEAR) | (victim_cell == CELL_W'(k));
        end
    end

    // next state
    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        drain_next     = drain_reg;
        tag_next       = tag_reg;
        hit_acc_next   = hit_acc_reg;
        fill_next      = fill_reg;
        z_next         = z_reg;
        w_next         = w_reg;
        use_rand_next  = use_rand_reg;
        victim_next    = victim_reg;
        lsl_next       = lsl_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        out_hit_next   = out_hit_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                row_next = row_reg + ROW_W'(1);
                if (row_reg == ROW_W'(BANK_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    tag_next     = addr_shifted[TAG_W-1:0];
                    hit_acc_next = 1'b0;
                    row_next     = '0;
                    state_next   = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                hit_acc_next = hit_acc_reg | chain_hit;
                row_next     = row_reg + ROW_W'(1);
                if (row_reg == ROW_W'(BANK_DEPTH - 1)) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last row's matches to ripple to the chain end
                hit_acc_next = hit_acc_reg | chain_hit;
                drain_next   = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(NUM_CELLS)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (hit_acc_reg) begin
                    state_next = ST_DONE;
                end else if (fill_reg < lines) begin
                    victim_next   = fill_reg[LINE_IDX_W-1:0];
                    fill_next     = fill_reg + FILL_W'(1);
                    use_rand_next = 1'b0;
                    state_next    = ST_WRITE;
                end else begin
                    z_next        = z_step;
                    w_next        = w_step;
                    use_rand_next = 1'b1;
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                row_next   = '0;
            end
        endcase

        // line size write clears every line through a fresh clearing pass
        if (cfg_we) begin
            lsl_next   = cfg_wdata;
            fill_next  = '0;
            row_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            drain_reg     <= '0;
            fill_reg      <= '0;
            z_reg         <= RNG_Z_INIT;
            w_reg         <= RNG_W_INIT;
            use_rand_reg  <= 1'b0;
            lsl_reg       <= LSL_RESET;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_acc_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            drain_reg     <= drain_next;
            fill_reg      <= fill_next;
            z_reg         <= z_next;
            w_reg         <= w_next;
            use_rand_reg  <= use_rand_next;
            lsl_reg       <= lsl_next;
            cmp_en_reg    <= (state_reg == ST_SWEEP);
            out_valid_reg <= out_valid_next;
            hit_acc_reg   <= hit_acc_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tag_reg     <= tag_next;
        victim_reg  <= victim_next;
        out_hit_reg <= out_hit_next;
    end

endmodule

`default_nettype wire

// File: src/fully_assoc_cache_random_replace.sv
// fully_assoc_cache_random_replace: top level, chain of tag cells and sequencer
// depends on facr_pkg, facr_ctrl, facr_cell
//
//   channel   ports                       beat
//   s_        s_valid s_ready s_addr      one byte address
//   m_        m_valid m_ready m_hit       hit flag for that address
//   cfg_      cfg_we cfg_wdata            line size log2, written at once
//
// For each beat every cell sweeps its 64-row tag bank, then the hit flag
// ripples down the 64-cell chain, followed by decide, a line write on a
// miss only, and output.
// After reset and after each line size write a clearing pass runs with
// s_ready low. One beat is in the sweep at a time; a finished result sits in
// the output register so the next beat can start under a stall.
`default_nettype none

module fully_assoc_cache_random_replace
    import facr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ADDR_BITS-1:0] s_addr,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit,
    input  wire logic                 cfg_we,
    input  wire logic [LSL_W-1:0]     cfg_wdata
);

    cell_ctl_t            ctl;
    logic [NUM_CELLS-1:0] wr_sel;
    logic [NUM_CELLS:0]   hit_link;

    // sequencer
    facr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_addr    (s_addr),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .chain_hit (hit_link[NUM_CELLS]),
        .ctl       (ctl),
        .wr_sel    (wr_sel)
    );

    // hit flag enters the chain low
    assign hit_link[0] = 1'b0;

    // row of tag cells
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        facr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .wr_sel  (wr_sel[k]),
            .hit_in  (hit_link[k]),
            .hit_out (hit_link[k+1])
        );
    end

endmodule

`default_nettype wire

// File: sim/tb.sv
// tb: self-checking bench for fully_assoc_cache_random_replace, lookup beats
// checked against a behavioral tag store with fill counter and mwc victim choice
// depends on facr_pkg and fully_assoc_cache_random_replace
`default_nettype none

module tb;
    import facr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 160;
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_GAP     = 24;
    localparam int HISTORY_LEN = 32;

    // one expected result beat
    typedef struct {
        logic [ADDR_BITS-1:0] addr;
        logic                 hit;
    } lookup_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [ADDR_BITS-1:0] s_addr    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_hit;
    logic                 cfg_we    = 1'b0;
    logic [LSL_W-1:0]     cfg_wdata = '0;

    // behavioral tag store
    logic [TAG_W-1:0] line_tag [MAX_LINES];
    bit               line_valid [MAX_LINES];
    logic [12:0]      fill_ptr;
    logic [31:0]      mwc_z;
    logic [31:0]      mwc_w;
    logic [LSL_W-1:0] cur_lsl;

    lookup_t pending_hits [$];
    int      error_count   = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      recv_hold     = 0;
    int      stall_count   = 0;

    fully_assoc_cache_random_replace dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_addr    (s_addr),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // offset bits in use for a line size setting
    function automatic int offset_bits(input logic [LSL_W-1:0] lsl);
        return (lsl < LSL_W'(4)) ? 4 : int'(lsl);
    endfunction

    // lines in use, capped at the storage depth
    function automatic logic [31:0] lines_in_use(input logic [LSL_W-1:0] lsl);
        logic [31:0] n;
        n = 32'(CACHE_BYTES) >> offset_bits(lsl);
        if (n > 32'(MAX_LINES)) begin
            n = 32'(MAX_LINES);
        end
        if (n == 32'd0) begin
            n = 32'd1;
        end
        return n;
    endfunction

    // drop every line, generator keeps running
    function automatic void clear_tag_store();
        for (int i = 0; i < MAX_LINES; i++) begin
            line_valid[i] = 1'b0;
        end
        fill_ptr = '0;
    endfunction

    // look up one address, allocate on a miss, return the hit flag
    function automatic logic lookup_line(input logic [ADDR_BITS-1:0] addr);
        logic [31:0] tag;
        logic [31:0] lines_n;
        logic [31:0] rnd;
        logic [31:0] victim;
        tag     = 32'(addr) >> offset_bits(cur_lsl);
        lines_n = lines_in_use(cur_lsl);
        for (int i = 0; i < int'(lines_n); i++) begin
            if (line_valid[i] && line_tag[i] == tag[TAG_W-1:0]) begin
                return 1'b1;
            end
        end
        if (32'(fill_ptr) < lines_n && !line_valid[fill_ptr]) begin
            line_tag[fill_ptr]   = tag[TAG_W-1:0];
            line_valid[fill_ptr] = 1'b1;
            fill_ptr             = fill_ptr + 13'd1;
        end else begin
            // multiply-with-carry step on both halves
            mwc_z  = 32'(mwc_z[15:0]) * 32'(RNG_Z_MUL) + 32'(mwc_z[31:16]);
            mwc_w  = 32'(mwc_w[15:0]) * 32'(RNG_W_MUL) + 32'(mwc_w[31:16]);
            rnd    = (mwc_z << 16) + mwc_w;
            victim = rnd % lines_n;
            line_tag[victim]   = tag[TAG_W-1:0];
            line_valid[victim] = 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // offer one address beat, predict its result once accepted
    task automatic send_addr(input logic [ADDR_BITS-1:0] addr);
        int      gap;
        lookup_t exp_beat;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_addr  <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_beat.addr = addr;
        exp_beat.hit  = lookup_line(addr);
        pending_hits.push_back(exp_beat);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_hits.size() != 0) @(posedge aclk);
    endtask

    // line size write, only with the block idle
    task automatic set_line_size(input logic [LSL_W-1:0] lsl);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= lsl;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_lsl  = lsl;
        clear_tag_store();
    endtask

    // field extremes, same-line offsets and single-bit tags at reset size
    task automatic test_directed();
        send_addr(26'h0000000);
        send_addr(26'h000000F);
        send_addr(26'h3FFFFFF);
        send_addr(26'h3FFFFF0);
        send_addr(26'h0000010);
        send_addr(26'h2AAAAAA);
        send_addr(26'h1555555);
        send_addr(26'h2AAAAA0);
        send_addr(26'h0000000);
        send_addr(26'h2000000);
        send_addr(26'h2000008);
        stop_sending();
    endtask

    // settings below the minimum act as 16-byte lines, then the largest lines
    task automatic test_line_size_range();
        set_line_size(LSL_W'(0));
        send_addr(26'h0123450);
        send_addr(26'h012345F);
        send_addr(26'h0123460);
        stop_sending();
        set_line_size(LSL_W'(3));
        send_addr(26'h0000040);
        send_addr(26'h000004F);
        stop_sending();
        set_line_size(LSL_W'(7));
        send_addr(26'h0001000);
        send_addr(26'h000107F);
        send_addr(26'h0001080);
        stop_sending();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_stall();
        recv_hold = HOLD_CYCLES;
        for (int i = 0; i < 10; i++) begin
            send_addr(ADDR_BITS'($urandom_range(3)) << 7);
        end
        stop_sending();
        wait_drained();
    endtask

    // mix of reuse, a compact working set and fresh addresses
    task automatic run_traffic(input logic [LSL_W-1:0] lsl, input int count,
                               input int send_pct, input int recv_pct);
        int                   shift;
        int                   pick;
        logic [31:0]          lines_n;
        logic [31:0]          region_tag;
        logic [ADDR_BITS-1:0] offset_mask;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] history [$];
        set_line_size(lsl);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        shift       = offset_bits(lsl);
        lines_n     = lines_in_use(lsl);
        offset_mask = ADDR_BITS'((1 << shift) - 1);
        region_tag  = $urandom;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 20 && history.size() > 0) begin
                addr = history[$urandom_range(history.size() - 1)];
                addr = (addr & ~offset_mask) | (ADDR_BITS'($urandom) & offset_mask);
            end else if (pick < 70) begin
                addr = ADDR_BITS'((region_tag + $urandom_range(2 * lines_n - 1)) << shift);
                addr = addr | (ADDR_BITS'($urandom) & offset_mask);
            end else begin
                addr = ADDR_BITS'($urandom);
            end
            send_addr(addr);
            history.push_back(addr);
            if (history.size() > HISTORY_LEN) begin
                void'(history.pop_front());
            end
        end
        stop_sending();
    endtask

    task automatic test_random_traffic();
        // enough misses at 128-byte lines to reach random replacement
        run_traffic(LSL_W'(7), 900, 16, 82);
        run_traffic(LSL_W'(5), 300, 82, 16);
        run_traffic(LSL_W'(6), 250, 82, 16);
        run_traffic(LSL_W'(4), 200, 0, 0);
        run_traffic(LSL_W'(2), 150, 0, 0);
    endtask

    // result check and receiver ready
    always @(posedge aclk) begin : result_check
        lookup_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("unexpected beat hit=%0b", m_hit));
            end else begin
                exp_beat = pending_hits.pop_front();
                if (m_hit !== exp_beat.hit) begin
                    report_mismatch($sformatf("addr 0x%07h hit=%0b expected %0b",
                                              exp_beat.addr, m_hit, exp_beat.hit));
                end
            end
        end
        if (recv_hold > 0) begin
            m_ready <= 1'b0;
            recv_hold--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat and no write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        mwc_z   = RNG_Z_INIT;
        mwc_w   = RNG_W_INIT;
        cur_lsl = LSL_RESET;
        clear_tag_store();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_line_size_range();
        test_output_stall();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
